// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== rtl/mof_pkg.sv =====
package mof_pkg;

	localparam int RING_DEPTH_DEFAULT = 4096;
	localparam logic [11:0] MAX_SYSEX_RESET = 12'd254;

	localparam logic [1:0] CMD_SHORT = 2'd0;
	localparam logic [1:0] CMD_SX_START = 2'd1;
	localparam logic [1:0] CMD_SX_DATA = 2'd2;
	localparam logic [1:0] CMD_TICK = 2'd3;

	localparam logic [2:0] RC_OK = 3'd0;
	localparam logic [2:0] RC_NO_SPACE = 3'd1;
	localparam logic [2:0] RC_UNKNOWN = 3'd2;
	localparam logic [2:0] RC_TOO_LARGE = 3'd3;
	localparam logic [2:0] RC_NO_SYSEX = 3'd4;
	localparam logic [2:0] RC_BUSY = 3'd5;

	localparam logic [7:0] SYSEX_START = 8'hF0;
	localparam logic [7:0] SYSEX_END = 8'hF7;

	localparam logic [3:0] ST_NOTE_OFF = 4'h8;
	localparam logic [3:0] ST_NOTE_ON = 4'h9;
	localparam logic [3:0] ST_POLY_AT = 4'hA;
	localparam logic [3:0] ST_CTRL = 4'hB;
	localparam logic [3:0] ST_PROG = 4'hC;
	localparam logic [3:0] ST_CHAN_AT = 4'hD;
	localparam logic [3:0] ST_PITCH = 4'hE;

	typedef struct packed {
		logic [1:0] command;
		logic [23:0] message_word;
		logic [15:0] sysex_length;
		logic [7:0] sysex_byte;
		logic tx_ready;
	} cmd_t;

	typedef struct packed {
		logic [2:0] result_code;
		logic tx_valid;
		logic [7:0] tx_byte;
		logic [11:0] free_space;
	} res_t;

endpackage

// ===== rtl/midi_output_framer_fifo.sv =====
// MIDI output framer: short messages and SysEx transfers are framed into a byte ring of
// RING_DEPTH bytes, and transmit ticks drain it one byte at a time. The block takes one
// command per clock cycle; each command gives exactly one result, registered in a pipeline
// stage and then in a three-entry output queue. Input stalls when the output queue and the
// pipeline stage in front of it together hold three results. The ring is four byte-wide
// single-port banks interleaved on the low two index bits, so the up to three bytes of one
// message are written in a single cycle; RING_DEPTH must be a multiple of four. The ring
// needs no clearing after reset, because only written entries are ever read.
`include "assert_macros.svh"

module midi_output_framer_fifo #(
	parameter int RING_DEPTH = mof_pkg::RING_DEPTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_stall,
	input mof_pkg::cmd_t cmd,
	output logic res_valid,
	input logic res_stall,
	output mof_pkg::res_t res,
	input logic cfg_we,
	input logic [11:0] cfg_wdata
);

	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam int CNT_W = $clog2(RING_DEPTH + 1);
	localparam int ROWS = RING_DEPTH / 4;
	localparam int ROW_W = IDX_W - 2;
	localparam int CMP_W = ((CNT_W > 16) ? CNT_W : 16) + 1;
	localparam int FS_W = (CNT_W > 12) ? CNT_W : 12;
	localparam int OQ_DEPTH = 3;
	localparam logic [CNT_W-1:0] CAP = CNT_W'(RING_DEPTH - 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [CNT_W-1:0] free_of(input logic [CNT_W-1:0] f);
		return (f >= CAP) ? '0 : CAP - f;
	endfunction

	logic [11:0] max_len_q;
	logic [IDX_W-1:0] wr_idx_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] fill_q;
	logic sx_open_q;
	logic [15:0] sx_rem_q;

	logic accept;
	logic [CNT_W-1:0] free_now;
	logic [7:0] status;
	logic [2:0] rc;
	logic [1:0] n_push;
	logic [7:0] push_byte [3];
	logic [IDX_W-1:0] push_idx [3];
	logic sx_open_d;
	logic [15:0] sx_rem_d;
	logic do_tx;
	logic sx_fits;
	logic [IDX_W-1:0] wr_idx_d;
	logic [IDX_W-1:0] rd_idx_d;
	logic [CNT_W-1:0] fill_d;
	logic [FS_W-1:0] free_wide;
	logic [11:0] free_sat;

	logic [3:0] bank_we;
	logic [ROW_W-1:0] bank_waddr [4];
	logic [7:0] bank_wdata [4];
	logic [7:0] bank_rdata_s1 [4];

	logic valid_s1;
	logic [2:0] rc_s1;
	logic txv_s1;
	logic [1:0] lane_s1;
	logic [11:0] free_s1;

	mof_pkg::res_t oq_q [OQ_DEPTH];
	mof_pkg::res_t oq_in;
	logic [1:0] oq_wp_q;
	logic [1:0] oq_rp_q;
	logic [1:0] oq_occ_q;
	logic oq_pop;

	assign cmd_stall = ({1'b0, oq_occ_q} + {2'b00, valid_s1}) >= 3'(OQ_DEPTH);
	assign accept = cmd_valid && !cmd_stall;
	assign free_now = free_of(fill_q);
	assign status = cmd.message_word[7:0];
	assign sx_fits = CMP_W'(free_now) >= (CMP_W'(cmd.sysex_length) + CMP_W'(2));

	always_comb begin
		rc = mof_pkg::RC_OK;
		n_push = 2'd0;
		push_byte[0] = 8'h00;
		push_byte[1] = 8'h00;
		push_byte[2] = 8'h00;
		sx_open_d = sx_open_q;
		sx_rem_d = sx_rem_q;
		do_tx = 1'b0;
		case (cmd.command)
			mof_pkg::CMD_SHORT: begin
				if (sx_open_q) begin
					rc = mof_pkg::RC_BUSY;
				end else if (free_now < CNT_W'(3)) begin
					rc = mof_pkg::RC_NO_SPACE;
				end else begin
					case (status[7:4])
						mof_pkg::ST_NOTE_OFF, mof_pkg::ST_NOTE_ON, mof_pkg::ST_POLY_AT,
						mof_pkg::ST_CTRL, mof_pkg::ST_PITCH: begin
							n_push = 2'd3;
							push_byte[0] = status;
							push_byte[1] = cmd.message_word[15:8];
							push_byte[2] = cmd.message_word[23:16];
						end
						mof_pkg::ST_PROG, mof_pkg::ST_CHAN_AT: begin
							n_push = 2'd2;
							push_byte[0] = status;
							push_byte[1] = cmd.message_word[15:8];
						end
						default: begin
							rc = mof_pkg::RC_UNKNOWN;
						end
					endcase
				end
			end
			mof_pkg::CMD_SX_START: begin
				if (sx_open_q) begin
					rc = mof_pkg::RC_BUSY;
				end else if (cmd.sysex_length > {4'h0, max_len_q}) begin
					rc = mof_pkg::RC_TOO_LARGE;
				end else if (!sx_fits) begin
					rc = mof_pkg::RC_NO_SPACE;
				end else begin
					push_byte[0] = mof_pkg::SYSEX_START;
					if (cmd.sysex_length == 16'd0) begin
						n_push = 2'd2;
						push_byte[1] = mof_pkg::SYSEX_END;
					end else begin
						n_push = 2'd1;
						sx_open_d = 1'b1;
						sx_rem_d = cmd.sysex_length;
					end
				end
			end
			mof_pkg::CMD_SX_DATA: begin
				if (!sx_open_q) begin
					rc = mof_pkg::RC_NO_SYSEX;
				end else begin
					push_byte[0] = {1'b0, cmd.sysex_byte[6:0]};
					sx_rem_d = sx_rem_q - 16'd1;
					if (sx_rem_q == 16'd1) begin
						n_push = 2'd2;
						push_byte[1] = mof_pkg::SYSEX_END;
						sx_open_d = 1'b0;
					end else begin
						n_push = 2'd1;
					end
				end
			end
			default: begin
				do_tx = (fill_q != '0) && cmd.tx_ready;
			end
		endcase
	end

	always_comb begin
		push_idx[0] = wr_idx_q;
		push_idx[1] = idx_inc(wr_idx_q);
		push_idx[2] = idx_inc(push_idx[1]);
		case (n_push)
			2'd0: wr_idx_d = wr_idx_q;
			2'd1: wr_idx_d = push_idx[1];
			2'd2: wr_idx_d = push_idx[2];
			default: wr_idx_d = idx_inc(push_idx[2]);
		endcase
		rd_idx_d = do_tx ? idx_inc(rd_idx_q) : rd_idx_q;
		fill_d = fill_q + CNT_W'(n_push) - CNT_W'(do_tx);
		free_wide = FS_W'(free_of(fill_d));
		free_sat = (free_wide > FS_W'(4095)) ? 12'hFFF : free_wide[11:0];
	end

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			bank_we[b] = 1'b0;
			bank_waddr[b] = '0;
			bank_wdata[b] = 8'h00;
			for (int k = 0; k < 3; k++) begin
				if (accept && (2'(k) < n_push) && (push_idx[k][1:0] == 2'(b))) begin
					bank_we[b] = 1'b1;
					bank_waddr[b] = push_idx[k][IDX_W-1:2];
					bank_wdata[b] = push_byte[k];
				end
			end
		end
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [7:0] mem [ROWS];

		always_ff @(posedge clk) begin
			if (bank_we[b]) begin
				mem[bank_waddr[b]] <= bank_wdata[b];
			end
			if (accept && do_tx) begin
				bank_rdata_s1[b] <= mem[rd_idx_q[IDX_W-1:2]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= mof_pkg::MAX_SYSEX_RESET;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			fill_q <= '0;
			sx_open_q <= 1'b0;
			sx_rem_q <= 16'd0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_len_q <= cfg_wdata;
			end
			valid_s1 <= accept;
			if (accept) begin
				wr_idx_q <= wr_idx_d;
				rd_idx_q <= rd_idx_d;
				fill_q <= fill_d;
				sx_open_q <= sx_open_d;
				sx_rem_q <= sx_rem_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rc_s1 <= rc;
			txv_s1 <= do_tx;
			lane_s1 <= rd_idx_q[1:0];
			free_s1 <= free_sat;
		end
	end

	assign oq_in = '{
		result_code: rc_s1,
		tx_valid: txv_s1,
		tx_byte: txv_s1 ? bank_rdata_s1[lane_s1] : 8'h00,
		free_space: free_s1
	};
	assign oq_pop = res_valid && !res_stall;
	assign res_valid = oq_occ_q != 2'd0;
	assign res = oq_q[oq_rp_q];

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			oq_q[oq_wp_q] <= oq_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wp_q <= 2'd0;
			oq_rp_q <= 2'd0;
			oq_occ_q <= 2'd0;
		end else begin
			if (valid_s1) begin
				oq_wp_q <= (oq_wp_q == 2'(OQ_DEPTH - 1)) ? 2'd0 : oq_wp_q + 2'd1;
			end
			if (oq_pop) begin
				oq_rp_q <= (oq_rp_q == 2'(OQ_DEPTH - 1)) ? 2'd0 : oq_rp_q + 2'd1;
			end
			oq_occ_q <= oq_occ_q + 2'(valid_s1) - 2'(oq_pop);
		end
	end

	// The ring never holds more bytes than its capacity.
	`ASSERT_NEVER(a_fill_cap, clk, arst_n, fill_q > CAP)
	// The output queue is never written while full.
	`ASSERT_NEVER(a_oq_ovf, clk, arst_n, oq_occ_q == 2'(OQ_DEPTH) && valid_s1 && !oq_pop)
	// An open SysEx transfer always has payload bytes still to come.
	`ASSERT_NEVER(a_sx_rem, clk, arst_n, sx_open_q && sx_rem_q == 16'd0)
	// A byte is sent to the transmitter only from a non-empty ring.
	`ASSERT_IMPLIES(a_tx_fill, clk, arst_n, accept && do_tx, fill_q != '0)

endmodule
